// ===== rtl/huffman_bit_packer_assert.svh =====
// Assertion macros for the Huffman bit packer RTL.
// Relies on clk and rst_n being in scope where a macro is used.
`ifndef HUFFMAN_BIT_PACKER_ASSERT_SVH
`define HUFFMAN_BIT_PACKER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define HBP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define HBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hbp_pkg.sv =====
// Shared types and constants for the Huffman bit packer.
// No dependencies.
package hbp_pkg;

  // Operation carried in the input tuser field.
  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_t;

  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int SYMBOLS_DEF      = 256;

  localparam int BYTE_W    = 8;
  localparam int SYM_W     = 8;
  localparam int WORD_W    = 32;   // code word port width
  localparam int LEN_W     = 6;    // code length width
  localparam int PEND_W    = 7;    // pending bit buffer
  localparam int PCNT_W    = 3;    // pending bit count
  localparam int PAD_W     = 3;
  localparam int ACC_W     = PEND_W + WORD_W;
  localparam int TOT_W     = 6;    // holds 0..ACC_W
  localparam int EMIT_W    = WORD_W;           // up to four bytes per item
  localparam int ECNT_W    = 3;    // holds 0..4 bytes

  localparam int IN_DATA_W  = 48;  // symbol + code_word + code_length, byte padded
  localparam int OUT_DATA_W = 16;  // out_byte + pad_bits, byte padded

endpackage

// ===== rtl/hbp_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module hbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/huffman_bit_packer.sv =====
// Huffman bit packer: the table read stage, the byte emitter and the output register lie
// between an input transaction and its first output byte; flushes take the same path.
// Throughput: one input transaction per cycle while each item yields at most one byte and
// the output does not stall; an n-byte encode (n <= 4) holds the emitter, one byte a cycle.
// Reset (rst_n low, synchronous) empties the pipeline and clears the pending bit buffer;
// the code table is not cleared and holds whatever was last loaded.
`include "huffman_bit_packer_assert.svh"

module huffman_bit_packer #(
  parameter int MAX_CODE_LEN = hbp_pkg::MAX_CODE_LEN_DEF,
  parameter int SYMBOLS      = hbp_pkg::SYMBOLS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [7:0] symbol, [39:8] code_word, [45:40] code_length, [47:46] zero
  input  logic [hbp_pkg::IN_DATA_W-1:0]    in_tdata,
  // [1:0] opcode
  input  logic [1:0]                       in_tuser,
  // result channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] out_byte, [10:8] pad_bits, [15:11] zero
  output logic [hbp_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tlast
);

  localparam int CODE_W  = (MAX_CODE_LEN < hbp_pkg::WORD_W) ? MAX_CODE_LEN : hbp_pkg::WORD_W;
  localparam int ADDR_W  = $clog2(SYMBOLS);
  localparam int ENTRY_W = CODE_W + hbp_pkg::LEN_W;
  localparam logic [hbp_pkg::SYM_W:0]   SYM_LIMIT = (hbp_pkg::SYM_W + 1)'(SYMBOLS);
  localparam logic [hbp_pkg::LEN_W-1:0] LEN_LIMIT = hbp_pkg::LEN_W'(CODE_W);

  // ---------------------------------------------------------------------------
  // Input unpacking
  // ---------------------------------------------------------------------------
  hbp_pkg::op_t                in_op;
  logic [hbp_pkg::SYM_W-1:0]   in_sym;
  logic [hbp_pkg::WORD_W-1:0]  in_word;
  logic [hbp_pkg::LEN_W-1:0]   in_len;
  logic [hbp_pkg::LEN_W-1:0]   in_len_sat;
  logic                        in_hit;     // symbol lies inside the table
  logic                        in_acc;

  assign in_op      = hbp_pkg::op_t'(in_tuser);
  assign in_sym     = in_tdata[7:0];
  assign in_word    = in_tdata[39:8];
  assign in_len     = in_tdata[45:40];
  assign in_len_sat = (in_len > LEN_LIMIT) ? LEN_LIMIT : in_len;
  assign in_hit     = ({1'b0, in_sym} < SYM_LIMIT);
  assign in_acc     = in_tvalid && in_tready;

  // ---------------------------------------------------------------------------
  // Code table: {length, code} per symbol. Loads write on the accept edge; an
  // encode reads on its own accept edge, so a load directly followed by an
  // encode of the same symbol already sees the new entry - no forwarding needed.
  // ---------------------------------------------------------------------------
  logic                 ram_wr_en;
  logic                 ram_rd_en;
  logic [ENTRY_W-1:0]   ram_wr_data;
  logic [ENTRY_W-1:0]   ram_rd_data;

  assign ram_wr_en   = in_acc && (in_op == hbp_pkg::OP_LOAD) && in_hit;
  assign ram_rd_en   = in_acc && (in_op == hbp_pkg::OP_ENCODE);
  assign ram_wr_data = {in_len_sat, in_word[CODE_W-1:0]};

  hbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SYMBOLS)
  ) u_code_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (in_sym[ADDR_W-1:0]),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (in_sym[ADDR_W-1:0]),
    .rd_data (ram_rd_data)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: table data arrives, bits are merged with the pending buffer.
  // Read data holds while the stage stalls since no new read is issued.
  // ---------------------------------------------------------------------------
  logic          s1_valid_r, s1_valid_nxt;
  hbp_pkg::op_t  s1_op_r,    s1_op_nxt;
  logic          s1_hit_r,   s1_hit_nxt;
  logic          s1_adv;

  logic [hbp_pkg::PEND_W-1:0] pend_bits_r, pend_bits_nxt;
  logic [hbp_pkg::PCNT_W-1:0] pend_cnt_r,  pend_cnt_nxt;

  // Byte emitter: up to four bytes, oldest in the top byte.
  logic [hbp_pkg::EMIT_W-1:0] emit_data_r, emit_data_nxt;
  logic [hbp_pkg::ECNT_W-1:0] emit_cnt_r,  emit_cnt_nxt;
  logic [hbp_pkg::PAD_W-1:0]  emit_pad_r,  emit_pad_nxt;
  logic                       emit_pop;
  logic                       emit_free;

  // Output register
  logic                           out_valid_r, out_valid_nxt;
  logic [hbp_pkg::OUT_DATA_W-1:0] out_data_r,  out_data_nxt;
  logic                           out_last_r,  out_last_nxt;
  logic                           out_free;

  assign out_free  = !out_valid_r || out_tready;
  assign emit_pop  = (emit_cnt_r != '0) && out_free;
  assign emit_free = (emit_cnt_r == '0) || ((emit_cnt_r == hbp_pkg::ECNT_W'(1)) && emit_pop);
  assign s1_adv    = s1_valid_r && emit_free;
  assign in_tready = !s1_valid_r || s1_adv;

  // Encode datapath
  logic [hbp_pkg::WORD_W-1:0]  rd_code;
  logic [hbp_pkg::LEN_W-1:0]   rd_len;
  logic [hbp_pkg::WORD_W:0]    code_mask;
  logic [hbp_pkg::ACC_W-1:0]   acc;
  logic [hbp_pkg::ACC_W-1:0]   acc_left;
  logic [hbp_pkg::TOT_W-1:0]   total;
  logic [hbp_pkg::TOT_W-1:0]   left_sh;
  logic [2:0]                  rem;
  logic [hbp_pkg::BYTE_W-1:0]  rem_mask;
  logic [hbp_pkg::ECNT_W-1:0]  enc_bytes;

  // Flush datapath
  logic [2*hbp_pkg::BYTE_W-2:0] flush_wide;
  logic [3:0]                   flush_sh;

  assign rd_code   = hbp_pkg::WORD_W'(ram_rd_data[CODE_W-1:0]);
  assign rd_len    = ram_rd_data[ENTRY_W-1:CODE_W];
  assign code_mask = ((hbp_pkg::WORD_W+1)'(1) << rd_len) - (hbp_pkg::WORD_W+1)'(1);
  assign acc       = (hbp_pkg::ACC_W'(pend_bits_r) << rd_len)
                   | hbp_pkg::ACC_W'(rd_code & code_mask[hbp_pkg::WORD_W-1:0]);
  assign total     = hbp_pkg::TOT_W'(pend_cnt_r) + rd_len;
  assign enc_bytes = total[5:3];
  assign rem       = total[2:0];
  assign rem_mask  = (hbp_pkg::BYTE_W'(1) << rem) - hbp_pkg::BYTE_W'(1);
  // left-align the valid bits so whole bytes sit at the top
  assign left_sh   = hbp_pkg::TOT_W'(hbp_pkg::ACC_W) - total;
  assign acc_left  = acc << left_sh;

  assign flush_sh   = 4'd8 - {1'b0, pend_cnt_r};
  assign flush_wide = (2*hbp_pkg::BYTE_W-1)'(pend_bits_r) << flush_sh;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_op_nxt    = s1_op_r;
    s1_hit_nxt   = s1_hit_r;
    if (in_tready) begin
      s1_valid_nxt = in_acc && ((in_op == hbp_pkg::OP_ENCODE) || (in_op == hbp_pkg::OP_FLUSH));
      s1_op_nxt    = in_op;
      s1_hit_nxt   = in_hit;
    end
  end

  always_comb begin
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    emit_data_nxt = emit_data_r;
    emit_cnt_nxt  = emit_cnt_r;
    emit_pad_nxt  = emit_pad_r;
    if (emit_pop) begin
      emit_data_nxt = emit_data_r << hbp_pkg::BYTE_W;
      emit_cnt_nxt  = emit_cnt_r - hbp_pkg::ECNT_W'(1);
    end
    if (s1_adv) begin
      case (s1_op_r)
        hbp_pkg::OP_ENCODE: begin
          if (s1_hit_r) begin
            emit_data_nxt = acc_left[hbp_pkg::ACC_W-1 -: hbp_pkg::EMIT_W];
            emit_cnt_nxt  = enc_bytes;
            emit_pad_nxt  = '0;
            pend_bits_nxt = acc[hbp_pkg::PEND_W-1:0] & rem_mask[hbp_pkg::PEND_W-1:0];
            pend_cnt_nxt  = rem;
          end
        end
        hbp_pkg::OP_FLUSH: begin
          if (pend_cnt_r != '0) begin
            emit_data_nxt = {flush_wide[hbp_pkg::BYTE_W-1:0],
                             (hbp_pkg::EMIT_W-hbp_pkg::BYTE_W)'(0)};
            emit_cnt_nxt  = hbp_pkg::ECNT_W'(1);
            emit_pad_nxt  = flush_sh[hbp_pkg::PAD_W-1:0];
            pend_bits_nxt = '0;
            pend_cnt_nxt  = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (emit_pop) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {5'b0, emit_pad_r, emit_data_r[hbp_pkg::EMIT_W-1 -: hbp_pkg::BYTE_W]};
      out_last_nxt  = (emit_cnt_r == hbp_pkg::ECNT_W'(1));
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
      emit_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r     <= s1_op_nxt;
    s1_hit_r    <= s1_hit_nxt;
    emit_data_r <= emit_data_nxt;
    emit_pad_r  <= emit_pad_nxt;
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `HBP_ASSERT_NOW(a_emit_cnt_max, 1'b1, emit_cnt_r <= hbp_pkg::ECNT_W'(4),
                  "emitter overfilled")
  `HBP_ASSERT_NOW(a_emit_reload, s1_adv,
                  (emit_cnt_r == '0) || (emit_cnt_r == hbp_pkg::ECNT_W'(1) && emit_pop),
                  "emitter reloaded while bytes remain")
  `HBP_ASSERT_NEXT(a_flush_clear, s1_adv && s1_op_r == hbp_pkg::OP_FLUSH, pend_cnt_r == '0,
                   "pending bits survive a flush")
  `HBP_ASSERT_NOW(a_out_source, $rose(out_valid_r), $past(emit_cnt_r) != '0,
                  "output raised without a queued byte")

endmodule

// ===== sim/huffman_bit_packer_tb.sv =====
// Self-checking testbench for huffman_bit_packer: directed table, then random traffic.
// Expected bytes come from a local bit-packing model kept in step with accepted transactions.
// Depends on rtl/hbp_pkg.sv and rtl/huffman_bit_packer.sv.
module huffman_bit_packer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_PERIOD = 8;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          TAIL_CYCLES = 20;    // margin for the output path, plus up to 4 bytes per item
  localparam int          RAND_PER_PHASE = 42;
  localparam int          SQUEEZE_CYCLES = 150;
  localparam int          N_DIR = 24;
  localparam logic [1:0]  OP_UNUSED = 2'd3;    // no operation behind this code

  // One input transaction as the block sees it
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  sym;
    logic [31:0] word;
    logic [5:0]  len;
  } pk_item_t;

  // One output byte with its side fields
  typedef struct packed {
    logic [7:0] data;
    logic [2:0] pad;
    logic       last;
  } pk_byte_t;

  // Directed row; typed rows carry at most one expected byte, written out by hand
  typedef struct {
    logic [1:0]  op;
    logic [7:0]  sym;
    logic [31:0] word;
    logic [5:0]  len;
    bit          typed;
    int          n_typed;
    logic [7:0]  t_data;
    logic [2:0]  t_pad;
  } dir_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [hbp_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]                     in_tuser = hbp_pkg::OP_LOAD;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [hbp_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tlast;

  // Local copy of the packer state
  logic [31:0] cw_tab  [256];
  logic [5:0]  len_tab [256];
  logic [6:0]  held_bits = '0;
  int          held_cnt = 0;
  pk_byte_t    step_out [4];

  pk_byte_t    due_bytes [$];       // bytes still owed by the block, oldest first
  logic [7:0]  live_syms [$];       // symbols whose table entry has been loaded
  bit          loaded [256];

  int          bad_bytes = 0;
  int          cycles = 0;
  int          tx_idle_pct = 31;
  int          rx_idle_pct = 57;
  bit          squeeze_go = 1'b0;
  bit          rx_hold = 1'b0;

  // Directed stimulus. Symbols 0..5 and 0xFF get hand-picked codes first, then the encode
  // rows walk through single bytes, sub-byte codes, full 32-bit codes and flushes.
  dir_row_t dir_tab [N_DIR] = '{
    // flush with nothing held: no byte
    '{hbp_pkg::OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 0, 8'h00, 3'd0},
    // unknown opcode with every data bit set: ignored
    '{OP_UNUSED,          8'hFF, 32'hFFFF_FFFF, 6'd63, 1'b1, 0, 8'h00, 3'd0},
    // loads: maximum length, plain byte, junk above length, saturating lengths, unused
    '{hbp_pkg::OP_LOAD,   8'h00, 32'hFFFF_FFFF, 6'd32, 1'b1, 0, 8'h00, 3'd0},
    '{hbp_pkg::OP_LOAD,   8'hFF, 32'h0000_00A5, 6'd8,  1'b1, 0, 8'h00, 3'd0},
    '{hbp_pkg::OP_LOAD,   8'h01, 32'hFFFF_FFFE, 6'd1,  1'b1, 0, 8'h00, 3'd0},
    '{hbp_pkg::OP_LOAD,   8'h02, 32'h0000_0005, 6'd63, 1'b1, 0, 8'h00, 3'd0},
    '{hbp_pkg::OP_LOAD,   8'h03, 32'hDEAD_BEEF, 6'd0,  1'b1, 0, 8'h00, 3'd0},
    '{hbp_pkg::OP_LOAD,   8'h04, 32'hFFFF_FFFB, 6'd3,  1'b1, 0, 8'h00, 3'd0},
    '{hbp_pkg::OP_LOAD,   8'h05, 32'h8000_0001, 6'd33, 1'b1, 0, 8'h00, 3'd0},
    // one whole byte straight out
    '{hbp_pkg::OP_ENCODE, 8'hFF, 32'h1234_5678, 6'd17, 1'b1, 1, 8'hA5, 3'd0},
    // unused symbol appends nothing
    '{hbp_pkg::OP_ENCODE, 8'h03, 32'h0000_0000, 6'd0,  1'b1, 0, 8'h00, 3'd0},
    // single zero bit, then flushed with seven pad bits
    '{hbp_pkg::OP_ENCODE, 8'h01, 32'hFFFF_FFFF, 6'd63, 1'b1, 0, 8'h00, 3'd0},
    '{hbp_pkg::OP_FLUSH,  8'h7E, 32'h5555_AAAA, 6'd21, 1'b1, 1, 8'h00, 3'd7},
    // three bits 011 flushed as 0110_0000
    '{hbp_pkg::OP_ENCODE, 8'h04, 32'h0000_0000, 6'd0,  1'b1, 0, 8'h00, 3'd0},
    '{hbp_pkg::OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 1, 8'h60, 3'd5},
    // long codes, with and without bits already held
    '{hbp_pkg::OP_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1'b0, 0, 8'h00, 3'd0},
    '{hbp_pkg::OP_ENCODE, 8'h04, 32'h0000_0000, 6'd0,  1'b0, 0, 8'h00, 3'd0},
    '{hbp_pkg::OP_ENCODE, 8'h00, 32'hA5A5_A5A5, 6'd42, 1'b0, 0, 8'h00, 3'd0},
    '{hbp_pkg::OP_ENCODE, 8'h02, 32'h0000_0000, 6'd0,  1'b0, 0, 8'h00, 3'd0},
    '{hbp_pkg::OP_ENCODE, 8'h05, 32'h0000_0000, 6'd0,  1'b0, 0, 8'h00, 3'd0},
    // unknown opcode while bits are held: buffer must survive
    '{OP_UNUSED,          8'h04, 32'h0000_0000, 6'd0,  1'b1, 0, 8'h00, 3'd0},
    '{hbp_pkg::OP_ENCODE, 8'h01, 32'h0000_0000, 6'd0,  1'b0, 0, 8'h00, 3'd0},
    '{hbp_pkg::OP_FLUSH,  8'hC3, 32'h0F0F_F0F0, 6'd9,  1'b0, 0, 8'h00, 3'd0},
    '{hbp_pkg::OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 0, 8'h00, 3'd0}
  };

  huffman_bit_packer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Run limit; reaching it means the block has hung or lost bytes
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Apply one accepted transaction to the local packer state; bytes go to step_out,
  // the count is returned.
  function automatic int pack_item(input pk_item_t it);
    logic [5:0]  clen;
    logic [31:0] code;
    logic [38:0] acc;
    int          total;
    int          n;
    n = 0;
    case (it.op)
      hbp_pkg::OP_LOAD: begin
        cw_tab[it.sym]  = it.word;
        len_tab[it.sym] = (it.len > 6'd32) ? 6'd32 : it.len;   // saturate long lengths
      end
      hbp_pkg::OP_ENCODE: begin
        clen = len_tab[it.sym];
        if (clen != 0) begin
          // bits of the code word above its length are dropped
          code  = 32'(cw_tab[it.sym] & ((64'd1 << clen) - 64'd1));
          acc   = ({32'd0, held_bits} << clen) | {7'd0, code};
          total = held_cnt + int'(clen);
          while (total >= 8) begin
            step_out[n].data = 8'(acc >> (total - 8));
            step_out[n].pad  = 3'd0;
            step_out[n].last = 1'b0;
            n++;
            total -= 8;
          end
          held_bits = 7'(acc & ((39'd1 << total) - 39'd1));
          held_cnt  = total;
          if (n > 0) step_out[n - 1].last = 1'b1;
        end
      end
      hbp_pkg::OP_FLUSH: begin
        if (held_cnt != 0) begin
          // held bits move to the top of the byte, zeros fill the rest
          step_out[0].data = 8'({1'b0, held_bits} << (8 - held_cnt));
          step_out[0].pad  = 3'(8 - held_cnt);
          step_out[0].last = 1'b1;
          n         = 1;
          held_bits = '0;
          held_cnt  = 0;
        end
      end
      default: ;   // unknown opcode leaves everything alone
    endcase
    return n;
  endfunction

  // Random transaction: mostly encodes of loaded symbols, with loads, flushes and noise
  function automatic pk_item_t next_item();
    pk_item_t it;
    int       roll;
    int       lroll;
    roll    = $urandom_range(99);
    it.sym  = 8'($urandom);
    it.word = $urandom;
    it.len  = 6'($urandom);
    if (roll < 68 && live_syms.size() != 0) begin
      // only symbols with a written entry may be encoded
      it.op  = hbp_pkg::OP_ENCODE;
      it.sym = live_syms[$urandom_range(live_syms.size() - 1)];
    end else if (roll < 82) begin
      it.op = hbp_pkg::OP_LOAD;
      lroll = $urandom_range(99);
      if (lroll < 6)       it.len = 6'd0;
      else if (lroll < 70) it.len = 6'($urandom_range(10, 1));
      else if (lroll < 92) it.len = 6'($urandom_range(32, 11));
      else                 it.len = 6'($urandom_range(63, 33));
    end else if (roll < 93) begin
      it.op = hbp_pkg::OP_FLUSH;
    end else begin
      it.op = OP_UNUSED;
    end
    return it;
  endfunction

  // Offer one transaction, hold it until accepted, then record what it owes
  task automatic send_item(input pk_item_t it, input bit typed, input int n_typed,
                           input logic [7:0] t_data, input logic [2:0] t_pad);
    int n;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.op;
    in_tdata  <= {2'b00, it.len, it.word, it.sym};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // transaction taken at this edge
    if (it.op == hbp_pkg::OP_LOAD && !loaded[it.sym]) begin
      loaded[it.sym] = 1'b1;
      live_syms.push_back(it.sym);
    end
    n = pack_item(it);
    if (typed) begin
      if (n_typed != 0) due_bytes.push_back('{data: t_data, pad: t_pad, last: 1'b1});
    end else begin
      for (int k = 0; k < n; k++) due_bytes.push_back(step_out[k]);
    end
  endtask

  task automatic note_fail(input string msg);
    bad_bytes++;
    if (bad_bytes <= 10) $display("%s", msg);
  endtask

  // Receiver back-pressure, random per cycle unless the long hold-off is running
  always @(posedge clk) begin
    out_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  // Long receiver hold-off so the block fills up and stalls its input
  initial begin : squeeze
    wait (squeeze_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (SQUEEZE_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Output checker: every byte transaction is matched against the oldest one owed
  always @(posedge clk) begin : byte_check
    pk_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_bytes.size() == 0) begin
        note_fail($sformatf("unexpected byte: data %02h pad %0d last %0b",
                            out_tdata[7:0], out_tdata[10:8], out_tlast));
      end else begin
        want = due_bytes.pop_front();
        if (out_tdata[7:0] !== want.data || out_tdata[10:8] !== want.pad ||
            out_tlast !== want.last) begin
          note_fail($sformatf("byte mismatch: got %02h pad %0d last %0b, want %02h pad %0d last %0b",
                              out_tdata[7:0], out_tdata[10:8], out_tlast,
                              want.data, want.pad, want.last));
        end
      end
    end
  end

  // Stimulus: reset, directed table, then three phases of random traffic
  initial begin : stimulus
    pk_item_t it;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      it = '{op: dir_tab[i].op, sym: dir_tab[i].sym, word: dir_tab[i].word, len: dir_tab[i].len};
      send_item(it, dir_tab[i].typed, dir_tab[i].n_typed, dir_tab[i].t_data, dir_tab[i].t_pad);
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 31; rx_idle_pct = 57; end
        1: begin tx_idle_pct = 57; rx_idle_pct = 31; end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          squeeze_go  = 1'b1;     // sender keeps offering while the receiver holds off
        end
      endcase
      repeat (RAND_PER_PHASE) send_item(next_item(), 1'b0, 0, 8'h00, 3'd0);
    end
    in_tvalid <= 1'b0;

    // drain, then give the block time to show any stray bytes
    while (due_bytes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (due_bytes.size() != 0) note_fail("bytes still owed at end of run");

    if (bad_bytes == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
